FILE: hdl/scfp_pkg.sv
`default_nettype none

package scfp_pkg;

  // Default payload length of one frame, in bytes.
  localparam int unsigned PAYLOAD_LEN_DEF = 4;

  // Framing and control bytes.
  localparam logic [7:0] HDR_BYTE = 8'h55;
  localparam logic [7:0] CR_BYTE  = 8'h0D;
  localparam logic [7:0] LF_BYTE  = 8'h0A;
  localparam logic [7:0] ON_BYTE  = 8'h41;
  localparam logic [7:0] OFF_BYTE = 8'h42;

  // Item kinds on the input channel.
  localparam logic REQ_BYTE    = 1'b0;
  localparam logic REQ_OVERRUN = 1'b1;

  // Command kinds, equal to the frame type byte that selects them.
  localparam logic [1:0] CMD_FREQ  = 2'd0;
  localparam logic [1:0] CMD_DUTY  = 2'd1;
  localparam logic [1:0] CMD_PULSE = 2'd2;

  typedef enum logic [2:0] {
    PH_SEEK = 3'd0,
    PH_TYPE = 3'd1,
    PH_DATA = 3'd2,
    PH_CR   = 3'd3,
    PH_LF   = 3'd4
  } phase_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_data;
  } in_item_t;

  typedef struct packed {
    logic        cmd_valid;
    logic [1:0]  cmd_kind;
    logic [31:0] cmd_value;
    logic        stop_output;
    logic        enabled;
    logic        refresh_request;
  } out_item_t;

endpackage

`default_nettype wire

FILE: hdl/scfp_core.sv
`default_nettype none

module scfp_core
  import scfp_pkg::*;
#(
  parameter int unsigned PAYLOAD_LEN = PAYLOAD_LEN_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      accept,
  input  wire in_item_t  in_item,
  output out_item_t      result
);

  // Only the first four payload bytes can reach the command value.
  localparam int unsigned KEEP_LEN = (PAYLOAD_LEN < 4) ? PAYLOAD_LEN : 4;
  localparam int unsigned CNT_W    = (PAYLOAD_LEN > 1) ? $clog2(PAYLOAD_LEN) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(PAYLOAD_LEN - 1);

  phase_t           phase_r, phase_nxt;
  logic [7:0]       type_r, type_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             en_r, en_nxt;
  logic             wr_en;
  logic [7:0]       pay_r [KEEP_LEN];
  logic [31:0]      value;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SEEK;
      type_r  <= '0;
      cnt_r   <= '0;
      en_r    <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      type_r  <= type_nxt;
      cnt_r   <= cnt_nxt;
      en_r    <= en_nxt;
    end
  end

  for (genvar k = 0; k < KEEP_LEN; k++) begin : g_pay
    always_ff @(posedge clk) begin
      if (accept && wr_en && (cnt_r == CNT_W'(k))) begin
        pay_r[k] <= in_item.rx_data;
      end
    end
  end

  // Little-endian assembly; bytes past the payload length read as zero.
  always_comb begin
    value = '0;
    for (int k = 0; k < KEEP_LEN; k++) begin
      value[8*k +: 8] = pay_r[k];
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    type_nxt  = type_r;
    cnt_nxt   = cnt_r;
    en_nxt    = en_r;
    wr_en     = 1'b0;
    result    = '0;

    if (in_item.req_type == REQ_OVERRUN) begin
      result.stop_output = 1'b1;
      en_nxt             = 1'b0;
    end else if ((in_item.rx_data == ON_BYTE) || (in_item.rx_data == OFF_BYTE)) begin
      en_nxt             = (in_item.rx_data == ON_BYTE);
      result.stop_output = 1'b1;
      phase_nxt          = PH_SEEK;
    end else begin
      case (phase_r)
        PH_SEEK: begin
          if (in_item.rx_data == HDR_BYTE) begin
            phase_nxt = PH_TYPE;
          end
        end
        PH_TYPE: begin
          type_nxt  = in_item.rx_data;
          cnt_nxt   = '0;
          phase_nxt = PH_DATA;
        end
        PH_DATA: begin
          wr_en   = 1'b1;
          cnt_nxt = cnt_r + CNT_W'(1);
          if (cnt_r == CNT_LAST) begin
            phase_nxt = PH_CR;
          end
        end
        PH_CR: begin
          phase_nxt = (in_item.rx_data == CR_BYTE) ? PH_LF : PH_SEEK;
        end
        PH_LF: begin
          if (in_item.rx_data == LF_BYTE) begin
            result.refresh_request = 1'b1;
            if (en_r && (type_r <= {6'd0, CMD_PULSE})) begin
              result.cmd_valid = 1'b1;
              result.cmd_kind  = type_r[1:0];
              result.cmd_value = value;
            end
          end
          phase_nxt = PH_SEEK;
        end
        default: begin
          phase_nxt = PH_SEEK;
        end
      endcase
    end

    result.enabled = en_nxt;
  end

endmodule

`default_nettype wire

FILE: hdl/serial_command_frame_parser_unit.sv
// Channel | Ports                          | Direction | Beat carries
// --------+--------------------------------+-----------+---------------------------------
// in      | in_valid, in_ready, in_data    | input     | byte or overrun event
// out     | out_valid, out_ready, out_data | output    | command, stop, enable, refresh
//
// Every input beat produces exactly one output beat, registered in the output or skid register.
// One beat per cycle is sustained while out_ready is high; the parser state
// update and result decode are a single short stage ahead of the output register.
// Reset is synchronous on rst_n and returns the parser to header search, disabled.
// A two-entry output buffer (output register plus skid register) lets one more
// beat in during an output stall; in_ready drops only while the skid entry is full.
`default_nettype none

module serial_command_frame_parser_unit
  import scfp_pkg::*;
#(
  parameter int unsigned PAYLOAD_LEN = PAYLOAD_LEN_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  out_item_t result;
  logic      accept;

  logic      main_valid_r, main_valid_nxt;
  out_item_t main_r;
  logic      skid_valid_r, skid_valid_nxt;
  out_item_t skid_r;
  logic      main_free;

  // The skid entry is the only thing that can block the input side.
  assign in_ready  = !skid_valid_r;
  assign accept    = in_valid && in_ready;
  assign main_free = out_ready || !main_valid_r;

  // The parser itself: state registers plus the per-beat decode.
  scfp_core #(
    .PAYLOAD_LEN(PAYLOAD_LEN)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .in_item(in_data),
    .result (result)
  );

  // When the output register drains, the skid entry moves forward first so
  // that beats leave in order. A full skid means in_ready is low, so no new
  // beat competes for the output register at that moment.
  always_comb begin
    main_valid_nxt = main_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (main_free) begin
      if (skid_valid_r) begin
        main_valid_nxt = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        main_valid_nxt = accept;
      end
    end else if (accept) begin
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      main_valid_r <= main_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // Payload registers carry no reset; their valid bits qualify them.
  always_ff @(posedge clk) begin
    if (main_free) begin
      if (skid_valid_r) begin
        main_r <= skid_r;
      end else if (accept) begin
        main_r <= result;
      end
    end else if (accept) begin
      skid_r <= result;
    end
  end

  assign out_valid = main_valid_r;
  assign out_data  = main_r;

endmodule

`default_nettype wire

FILE: hdl/scfp_checker.sv
`default_nettype none

module scfp_checker
  import scfp_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_ready,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_item_t out_data
);

  // A stalled result beat keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output beat changed while stalled");

  // A new result only appears right after an input beat was taken.
  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("output beat without a preceding input beat");

  // Commands come only from a complete frame while enabled.
  a_cmd_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.cmd_valid |->
      out_data.enabled && out_data.refresh_request && (out_data.cmd_kind != 2'd3))
    else $error("command without an enabled complete frame");

  // A stop beat never also completes a frame.
  a_stop_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.stop_output |->
      !out_data.refresh_request && !out_data.cmd_valid)
    else $error("stop beat also reports a frame");

  // Command fields are zero when there is no command.
  a_cmd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.cmd_valid |->
      (out_data.cmd_kind == CMD_FREQ) && (out_data.cmd_value == 32'd0))
    else $error("command fields set without a command");

endmodule

bind serial_command_frame_parser_unit scfp_checker u_scfp_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

`default_nettype wire
